FILE: rtl/mrt_pkg.sv
// Shared types, constants and helper functions for the D2Q9 MRT collision pipeline.
package mrt_pkg;

  localparam int WORD_W = 32;
  localparam int RATE_W = 30;
  localparam int RATE_BITS = 28;
  localparam int FRAC_BITS_DEF = 28;
  localparam int NDIR = 9;
  localparam int DIFF_W = 33;
  localparam int MAG_W = 36;
  localparam int SPLIT = 18;
  localparam int REM_W = 4;
  localparam int LOW_W = REM_W + SPLIT;
  localparam int NORM_W = MAG_W + 1;
  localparam int SAT_IN_W = 72;
  localparam int CFG_IDX_W = 3;
  localparam int RECIP_K = 26;
  localparam int RECIP_W = RECIP_K + 1;
  localparam int RECIP1 = (2 ** RECIP_K);
  localparam int RECIP3 = ((2 ** RECIP_K) + 2) / 3;
  localparam int RECIP9 = ((2 ** RECIP_K) + 8) / 9;

  localparam logic [CFG_IDX_W-1:0] CFG_ENERGY = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ENERGY_SQ = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HEAT_X = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HEAT_Y = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SHEAR = 3'd4;

  localparam logic [RATE_W-1:0] RST_ENERGY = 30'd295279002;
  localparam logic [RATE_W-1:0] RST_ENERGY_SQ = 30'd281857229;
  localparam logic [RATE_W-1:0] RST_HEAT = 30'd281857229;
  localparam logic [RATE_W-1:0] RST_SHEAR = 30'd533668899;

  // Normalizer d = 2^shift * odd; rounding adds d/2 before the division.
  localparam int NORM_HALF [NDIR] = '{4, 18, 18, 3, 6, 3, 6, 2, 2};
  localparam int NORM_SHIFT [NDIR] = '{0, 2, 2, 1, 2, 1, 2, 2, 2};
  localparam int NORM_ODD [NDIR] = '{9, 9, 9, 3, 3, 3, 3, 1, 1};
  localparam int NORM_RECIP [NDIR] = '{RECIP9, RECIP9, RECIP9, RECIP3, RECIP3,
                                       RECIP3, RECIP3, RECIP1, RECIP1};

  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic [RATE_W-1:0] rate_t;
  typedef logic signed [2*WORD_W-1:0] prod_t;
  typedef logic signed [DIFF_W-1:0] diff_t;
  typedef logic signed [NORM_W-1:0] norm_t;
  typedef word_t word9_t [NDIR];
  typedef rate_t rate9_t [NDIR];

  function automatic word_t sat_word(input logic signed [SAT_IN_W-1:0] v);
    word_t r;
    if (v > SAT_IN_W'(32'sh7FFFFFFF)) begin
      r = 32'sh7FFFFFFF;
    end else if (v < -SAT_IN_W'(33'sh080000000)) begin
      r = 32'sh80000000;
    end else begin
      r = word_t'(v);
    end
    return r;
  endfunction

endpackage

FILE: rtl/mrt_moments.sv
// First stage: the nine saturated moments and the raw velocity and momentum products.
module mrt_moments (
  input  logic                clk,
  input  logic                en,
  input  mrt_pkg::word9_t     f,
  input  mrt_pkg::word_t      rho,
  input  mrt_pkg::word_t      ux,
  input  mrt_pkg::word_t      uy,
  output mrt_pkg::word9_t     m,
  output mrt_pkg::word_t      rho_q,
  output mrt_pkg::prod_t      p_uu,
  output mrt_pkg::prod_t      p_vv,
  output mrt_pkg::prod_t      p_uv,
  output mrt_pkg::prod_t      p_ru,
  output mrt_pkg::prod_t      p_rv
);

  logic signed [37:0] e [mrt_pkg::NDIR];
  logic signed [37:0] s [mrt_pkg::NDIR];

  always_comb begin
    for (int k = 0; k < mrt_pkg::NDIR; k++) begin
      e[k] = 38'(f[k]);
    end
    s[0] = e[0] + e[1] + e[2] + e[3] + e[4] + e[5] + e[6] + e[7] + e[8];
    s[1] = -(e[0] <<< 2) - e[1] - e[2] - e[3] - e[4] + ((e[5] + e[6] + e[7] + e[8]) <<< 1);
    s[2] = (e[0] <<< 2) - ((e[1] + e[2] + e[3] + e[4]) <<< 1) + e[5] + e[6] + e[7] + e[8];
    s[3] = e[1] - e[3] + e[5] - e[6] - e[7] + e[8];
    s[4] = -((e[1] - e[3]) <<< 1) + e[5] - e[6] - e[7] + e[8];
    s[5] = e[2] - e[4] + e[5] + e[6] - e[7] - e[8];
    s[6] = -((e[2] - e[4]) <<< 1) + e[5] + e[6] - e[7] - e[8];
    s[7] = e[1] - e[2] + e[3] - e[4];
    s[8] = e[5] - e[6] + e[7] - e[8];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < mrt_pkg::NDIR; k++) begin
        m[k] <= mrt_pkg::sat_word(mrt_pkg::SAT_IN_W'(s[k]));
      end
      rho_q <= rho;
      p_uu <= ux * ux;
      p_vv <= uy * uy;
      p_uv <= ux * uy;
      p_ru <= rho * ux;
      p_rv <= rho * uy;
    end
  end

endmodule

FILE: rtl/mrt_equil.sv
// Three stages that build the equilibrium moments and the moment differences.
module mrt_equil #(
  parameter int FRAC_BITS = mrt_pkg::FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                en,
  input  mrt_pkg::word9_t     m_in,
  input  mrt_pkg::word_t      rho,
  input  mrt_pkg::prod_t      p_uu,
  input  mrt_pkg::prod_t      p_vv,
  input  mrt_pkg::prod_t      p_uv,
  input  mrt_pkg::prod_t      p_ru,
  input  mrt_pkg::prod_t      p_rv,
  output mrt_pkg::word9_t     m_out,
  output mrt_pkg::diff_t      d [mrt_pkg::NDIR]
);

  localparam logic signed [64:0] HALF_F = 65'sd1 <<< (FRAC_BITS - 1);
  localparam logic signed [71:0] ONE = 72'sd1 <<< FRAC_BITS;

  logic signed [64:0] sx, sy;
  logic signed [71:0] usq3;
  mrt_pkg::word_t usq, udif, uv, tru, trv;
  mrt_pkg::word_t a1, a2, b_udif, b_uv, b_eq4, b_eq6, b_rho;
  mrt_pkg::word9_t b_m, c_m;
  mrt_pkg::prod_t c_p1, c_p2, c_p7, c_p8;
  mrt_pkg::word_t c_eq4, c_eq6;
  mrt_pkg::word_t eq [mrt_pkg::NDIR];

  function automatic mrt_pkg::word_t rnd_sat(input mrt_pkg::prod_t p);
    logic signed [64:0] t;
    t = (65'(p) + HALF_F) >>> FRAC_BITS;
    return mrt_pkg::sat_word(mrt_pkg::SAT_IN_W'(t));
  endfunction

  always_comb begin
    sx = (65'(p_uu) + HALF_F) >>> FRAC_BITS;
    sy = (65'(p_vv) + HALF_F) >>> FRAC_BITS;
    usq = mrt_pkg::sat_word(mrt_pkg::SAT_IN_W'(sx + sy));
    udif = mrt_pkg::sat_word(mrt_pkg::SAT_IN_W'(sx - sy));
    uv = rnd_sat(p_uv);
    tru = rnd_sat(p_ru);
    trv = rnd_sat(p_rv);
    usq3 = (72'(usq) <<< 1) + 72'(usq);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_m <= m_in;
      b_rho <= rho;
      a1 <= mrt_pkg::sat_word(usq3 - (ONE <<< 1));
      a2 <= mrt_pkg::sat_word(ONE - usq3);
      b_udif <= udif;
      b_uv <= uv;
      b_eq4 <= mrt_pkg::sat_word(-72'(tru));
      b_eq6 <= mrt_pkg::sat_word(-72'(trv));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_m <= b_m;
      c_p1 <= b_rho * a1;
      c_p2 <= b_rho * a2;
      c_p7 <= b_rho * b_udif;
      c_p8 <= b_rho * b_uv;
      c_eq4 <= b_eq4;
      c_eq6 <= b_eq6;
    end
  end

  always_comb begin
    eq[0] = '0;
    eq[1] = rnd_sat(c_p1);
    eq[2] = rnd_sat(c_p2);
    eq[3] = '0;
    eq[4] = c_eq4;
    eq[5] = '0;
    eq[6] = c_eq6;
    eq[7] = rnd_sat(c_p7);
    eq[8] = rnd_sat(c_p8);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < mrt_pkg::NDIR; k++) begin
        m_out[k] <= c_m[k];
        d[k] <= mrt_pkg::DIFF_W'(c_m[k]) - mrt_pkg::DIFF_W'(eq[k]);
      end
    end
  end

endmodule

FILE: rtl/mrt_relax.sv
// Four stages that relax each moment and divide it by its normalizer with rounding.
module mrt_relax (
  input  logic                clk,
  input  logic                en,
  input  mrt_pkg::rate9_t     rate,
  input  mrt_pkg::word9_t     m,
  input  mrt_pkg::diff_t      d [mrt_pkg::NDIR],
  output mrt_pkg::norm_t      n [mrt_pkg::NDIR]
);

  localparam mrt_pkg::prod_t HALF_R = 64'sd1 <<< (mrt_pkg::RATE_BITS - 1);

  mrt_pkg::word_t e_m [mrt_pkg::NDIR];
  mrt_pkg::prod_t e_p [mrt_pkg::NDIR];
  logic [mrt_pkg::MAG_W-1:0] f_a [mrt_pkg::NDIR];
  logic [mrt_pkg::NDIR-1:0] f_neg, g_neg;
  logic [mrt_pkg::SPLIT-1:0] g_qh [mrt_pkg::NDIR];
  logic [mrt_pkg::LOW_W-1:0] g_y [mrt_pkg::NDIR];

  logic signed [mrt_pkg::MAG_W-1:0] r [mrt_pkg::NDIR];
  logic [mrt_pkg::MAG_W-1:0] mag [mrt_pkg::NDIR];
  logic [mrt_pkg::SPLIT+mrt_pkg::RECIP_W-1:0] hp [mrt_pkg::NDIR];
  logic [mrt_pkg::SPLIT-1:0] qh [mrt_pkg::NDIR];
  logic [mrt_pkg::SPLIT-1:0] rh [mrt_pkg::NDIR];
  logic [mrt_pkg::LOW_W+mrt_pkg::RECIP_W-1:0] lp [mrt_pkg::NDIR];
  logic [mrt_pkg::NORM_W-1:0] q [mrt_pkg::NDIR];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < mrt_pkg::NDIR; k++) begin
        e_m[k] <= m[k];
        e_p[k] <= 64'($signed({1'b0, rate[k]})) * 64'(d[k]);
      end
    end
  end

  always_comb begin
    for (int k = 0; k < mrt_pkg::NDIR; k++) begin
      r[k] = mrt_pkg::MAG_W'(e_m[k])
           - mrt_pkg::MAG_W'((e_p[k] + HALF_R) >>> mrt_pkg::RATE_BITS);
      mag[k] = r[k][mrt_pkg::MAG_W-1] ? mrt_pkg::MAG_W'(-r[k]) : mrt_pkg::MAG_W'(r[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < mrt_pkg::NDIR; k++) begin
        f_neg[k] <= r[k][mrt_pkg::MAG_W-1];
        f_a[k] <= (mag[k] + mrt_pkg::MAG_W'(mrt_pkg::NORM_HALF[k])) >> mrt_pkg::NORM_SHIFT[k];
      end
    end
  end

  always_comb begin
    for (int k = 0; k < mrt_pkg::NDIR; k++) begin
      hp[k] = (mrt_pkg::SPLIT+mrt_pkg::RECIP_W)'(f_a[k][mrt_pkg::MAG_W-1:mrt_pkg::SPLIT])
            * (mrt_pkg::SPLIT+mrt_pkg::RECIP_W)'(mrt_pkg::NORM_RECIP[k]);
      qh[k] = mrt_pkg::SPLIT'(hp[k] >> mrt_pkg::RECIP_K);
      rh[k] = f_a[k][mrt_pkg::MAG_W-1:mrt_pkg::SPLIT]
            - mrt_pkg::SPLIT'(qh[k] * mrt_pkg::SPLIT'(mrt_pkg::NORM_ODD[k]));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < mrt_pkg::NDIR; k++) begin
        g_neg[k] <= f_neg[k];
        g_qh[k] <= qh[k];
        g_y[k] <= {rh[k][mrt_pkg::REM_W-1:0], f_a[k][mrt_pkg::SPLIT-1:0]};
      end
    end
  end

  always_comb begin
    for (int k = 0; k < mrt_pkg::NDIR; k++) begin
      lp[k] = (mrt_pkg::LOW_W+mrt_pkg::RECIP_W)'(g_y[k])
            * (mrt_pkg::LOW_W+mrt_pkg::RECIP_W)'(mrt_pkg::NORM_RECIP[k]);
      q[k] = {1'b0, g_qh[k], lp[k][mrt_pkg::RECIP_K +: mrt_pkg::SPLIT]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < mrt_pkg::NDIR; k++) begin
        n[k] <= g_neg[k] ? -$signed(q[k]) : $signed(q[k]);
      end
    end
  end

endmodule

FILE: rtl/mrt_back.sv
// Final stage: back transform of the normalized moments and output saturation.
module mrt_back (
  input  logic                clk,
  input  logic                en,
  input  mrt_pkg::norm_t      n [mrt_pkg::NDIR],
  output mrt_pkg::word9_t     post
);

  logic signed [41:0] x [mrt_pkg::NDIR];
  logic signed [41:0] p [mrt_pkg::NDIR];
  logic signed [41:0] base, corner;

  always_comb begin
    for (int k = 0; k < mrt_pkg::NDIR; k++) begin
      x[k] = 42'(n[k]);
    end
    base = x[0] - x[1];
    corner = x[0] + (x[1] <<< 1) + x[2];
    p[0] = x[0] - ((x[1] - x[2]) <<< 2);
    p[1] = base - ((x[2] + x[4]) <<< 1) + x[3] + x[7];
    p[2] = base - ((x[2] + x[6]) <<< 1) + x[5] - x[7];
    p[3] = base - ((x[2] - x[4]) <<< 1) - x[3] + x[7];
    p[4] = base - ((x[2] - x[6]) <<< 1) - x[5] - x[7];
    p[5] = corner + x[3] + x[4] + x[5] + x[6] + x[8];
    p[6] = corner - x[3] - x[4] + x[5] + x[6] - x[8];
    p[7] = corner - x[3] - x[4] - x[5] - x[6] + x[8];
    p[8] = corner + x[3] + x[4] - x[5] - x[6] - x[8];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < mrt_pkg::NDIR; k++) begin
        post[k] <= mrt_pkg::sat_word(mrt_pkg::SAT_IN_W'(p[k]));
      end
    end
  end

endmodule

FILE: rtl/d2q9_mrt_collision.sv
// D2Q9 MRT collision: nine-stage pipeline, one node per cycle when not stalled.
// The block takes one node in every cycle while the output is not stalled and
// returns its nine post-collision values. The depth of the pipeline is set by the
// multiplier chain (velocity products, density products, rate products) and
// the two-step reciprocal division by the normalizers. The last stage is the
// output register; while it holds an untaken result the whole pipeline stops,
// so no item is lost or repeated. Rate registers may be written at any idle time.
module d2q9_mrt_collision #(
  parameter int FRAC_BITS = mrt_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [mrt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mrt_pkg::RATE_W-1:0]    cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [31:0]            f_rest,
  input  logic signed [31:0]            f_east,
  input  logic signed [31:0]            f_north,
  input  logic signed [31:0]            f_west,
  input  logic signed [31:0]            f_south,
  input  logic signed [31:0]            f_ne,
  input  logic signed [31:0]            f_nw,
  input  logic signed [31:0]            f_sw,
  input  logic signed [31:0]            f_se,
  input  logic signed [31:0]            density,
  input  logic signed [31:0]            vel_x,
  input  logic signed [31:0]            vel_y,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [31:0]            post_rest,
  output logic signed [31:0]            post_east,
  output logic signed [31:0]            post_north,
  output logic signed [31:0]            post_west,
  output logic signed [31:0]            post_south,
  output logic signed [31:0]            post_ne,
  output logic signed [31:0]            post_nw,
  output logic signed [31:0]            post_sw,
  output logic signed [31:0]            post_se
);

  localparam int STAGES = 9;

  logic en;
  logic [STAGES-1:0] vld;
  mrt_pkg::rate_t rate_energy, rate_energy_sq, rate_heat_x, rate_heat_y, rate_shear;
  mrt_pkg::rate9_t rate;
  mrt_pkg::word9_t f, m_a, m_d, post;
  mrt_pkg::word_t rho_a;
  mrt_pkg::prod_t p_uu, p_vv, p_uv, p_ru, p_rv;
  mrt_pkg::diff_t d [mrt_pkg::NDIR];
  mrt_pkg::norm_t n [mrt_pkg::NDIR];

  assign en = !vld[STAGES-1] || out_ready;
  assign in_ready = en;
  assign out_valid = vld[STAGES-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[STAGES-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rate_energy <= mrt_pkg::RST_ENERGY;
      rate_energy_sq <= mrt_pkg::RST_ENERGY_SQ;
      rate_heat_x <= mrt_pkg::RST_HEAT;
      rate_heat_y <= mrt_pkg::RST_HEAT;
      rate_shear <= mrt_pkg::RST_SHEAR;
    end else if (cfg_we) begin
      case (cfg_index)
        mrt_pkg::CFG_ENERGY: rate_energy <= cfg_data;
        mrt_pkg::CFG_ENERGY_SQ: rate_energy_sq <= cfg_data;
        mrt_pkg::CFG_HEAT_X: rate_heat_x <= cfg_data;
        mrt_pkg::CFG_HEAT_Y: rate_heat_y <= cfg_data;
        mrt_pkg::CFG_SHEAR: rate_shear <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    rate[0] = '0;
    rate[1] = rate_energy;
    rate[2] = rate_energy_sq;
    rate[3] = '0;
    rate[4] = rate_heat_x;
    rate[5] = '0;
    rate[6] = rate_heat_y;
    rate[7] = rate_shear;
    rate[8] = rate_shear;
    f[0] = f_rest;
    f[1] = f_east;
    f[2] = f_north;
    f[3] = f_west;
    f[4] = f_south;
    f[5] = f_ne;
    f[6] = f_nw;
    f[7] = f_sw;
    f[8] = f_se;
  end

  mrt_moments u_moments (
    .clk(clk), .en(en), .f(f), .rho(density), .ux(vel_x), .uy(vel_y),
    .m(m_a), .rho_q(rho_a), .p_uu(p_uu), .p_vv(p_vv), .p_uv(p_uv),
    .p_ru(p_ru), .p_rv(p_rv)
  );

  mrt_equil #(.FRAC_BITS(FRAC_BITS)) u_equil (
    .clk(clk), .en(en), .m_in(m_a), .rho(rho_a), .p_uu(p_uu), .p_vv(p_vv),
    .p_uv(p_uv), .p_ru(p_ru), .p_rv(p_rv), .m_out(m_d), .d(d)
  );

  mrt_relax u_relax (
    .clk(clk), .en(en), .rate(rate), .m(m_d), .d(d), .n(n)
  );

  mrt_back u_back (
    .clk(clk), .en(en), .n(n), .post(post)
  );

  assign post_rest = post[0];
  assign post_east = post[1];
  assign post_north = post[2];
  assign post_west = post[3];
  assign post_south = post[4];
  assign post_ne = post[5];
  assign post_nw = post[6];
  assign post_sw = post[7];
  assign post_se = post[8];

endmodule

FILE: rtl/mrt_check.sv
// Port-level checker for the collision block and its bind to the top level.
module mrt_check (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] post_rest,
  input logic [31:0] post_se
);

  a_reset_empty: assert property (@(posedge clk) !rst && $past(rst) |-> !out_valid)
    else $error("Output valid after reset.");

  a_ready_link: assert property (@(posedge clk) disable iff (rst)
    in_ready == (!out_valid || out_ready))
    else $error("Input ready does not follow the output stall.");

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("Output valid dropped before transfer.");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(post_rest) && $stable(post_se))
    else $error("Output payload changed before transfer.");

endmodule

bind d2q9_mrt_collision mrt_check u_mrt_check (
  .clk(clk), .rst(rst), .in_ready(in_ready), .out_valid(out_valid),
  .out_ready(out_ready), .post_rest(post_rest), .post_se(post_se)
);

FILE: verif/tb.sv
// Self-checking testbench for the D2Q9 MRT collision block, with its own collision predictor.
`timescale 1ns / 1ps

module tb;

  localparam longint ONE = 64'sd1 <<< 28;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int IDLE_PCT = 19;

  typedef struct {
    logic signed [31:0] f [9];
    logic signed [31:0] rho;
    logic signed [31:0] ux;
    logic signed [31:0] uy;
  } node_t;

  typedef struct {
    logic signed [31:0] p [9];
  } post_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [mrt_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [mrt_pkg::RATE_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [31:0] f_rest = '0, f_east = '0, f_north = '0, f_west = '0, f_south = '0;
  logic signed [31:0] f_ne = '0, f_nw = '0, f_sw = '0, f_se = '0;
  logic signed [31:0] density = '0, vel_x = '0, vel_y = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] post_rest, post_east, post_north, post_west, post_south;
  logic signed [31:0] post_ne, post_nw, post_sw, post_se;

  d2q9_mrt_collision dut (.*);

  always #2 clk = ~clk;

  node_t pending [$];
  post_t post_q [$];
  node_t cur_node;
  longint rate_cfg [5];
  int errors = 0;
  int out_count = 0;
  int quiet = 0;
  int hold = 0;
  bit hold_done = 0;
  bit done = 0;

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint rnd_shift(longint v);
    return (v + (64'sd1 <<< 27)) >>> 28;
  endfunction

  function automatic longint qmul(longint a, longint b);
    return sat32(rnd_shift(a * b));
  endfunction

  function automatic longint rnd_div(longint v, longint d);
    if (v >= 0) return (v + d / 2) / d;
    return -((-v + d / 2) / d);
  endfunction

  function automatic post_t collide(node_t n);
    longint f [9], m [9], eq [9], rt [9], p [9];
    longint rho, ux, uy, sx, sy, usq, udif, uv, r;
    longint nd [9] = '{9, 36, 36, 6, 12, 6, 12, 4, 4};
    post_t res;
    for (int k = 0; k < 9; k++) f[k] = n.f[k];
    rho = n.rho;
    ux = n.ux;
    uy = n.uy;
    m[0] = f[0] + f[1] + f[2] + f[3] + f[4] + f[5] + f[6] + f[7] + f[8];
    m[1] = -4 * f[0] - f[1] - f[2] - f[3] - f[4] + 2 * (f[5] + f[6] + f[7] + f[8]);
    m[2] = 4 * f[0] - 2 * (f[1] + f[2] + f[3] + f[4]) + f[5] + f[6] + f[7] + f[8];
    m[3] = f[1] - f[3] + f[5] - f[6] - f[7] + f[8];
    m[4] = -2 * (f[1] - f[3]) + f[5] - f[6] - f[7] + f[8];
    m[5] = f[2] - f[4] + f[5] + f[6] - f[7] - f[8];
    m[6] = -2 * (f[2] - f[4]) + f[5] + f[6] - f[7] - f[8];
    m[7] = f[1] - f[2] + f[3] - f[4];
    m[8] = f[5] - f[6] + f[7] - f[8];
    for (int k = 0; k < 9; k++) m[k] = sat32(m[k]);
    sx = rnd_shift(ux * ux);
    sy = rnd_shift(uy * uy);
    usq = sat32(sx + sy);
    udif = sat32(sx - sy);
    uv = qmul(ux, uy);
    eq[0] = 0;
    eq[3] = 0;
    eq[5] = 0;
    eq[1] = qmul(rho, sat32(3 * usq - 2 * ONE));
    eq[2] = qmul(rho, sat32(ONE - 3 * usq));
    eq[4] = sat32(-qmul(rho, ux));
    eq[6] = sat32(-qmul(rho, uy));
    eq[7] = qmul(rho, udif);
    eq[8] = qmul(rho, uv);
    rt = '{0, rate_cfg[mrt_pkg::CFG_ENERGY], rate_cfg[mrt_pkg::CFG_ENERGY_SQ], 0,
           rate_cfg[mrt_pkg::CFG_HEAT_X], 0, rate_cfg[mrt_pkg::CFG_HEAT_Y],
           rate_cfg[mrt_pkg::CFG_SHEAR], rate_cfg[mrt_pkg::CFG_SHEAR]};
    for (int k = 0; k < 9; k++) begin
      r = m[k];
      if (rt[k] != 0) r = m[k] - rnd_shift(rt[k] * (m[k] - eq[k]));
      m[k] = rnd_div(r, nd[k]);
    end
    p[0] = m[0] - 4 * (m[1] - m[2]);
    p[1] = m[0] - m[1] - 2 * (m[2] + m[4]) + m[3] + m[7];
    p[2] = m[0] - m[1] - 2 * (m[2] + m[6]) + m[5] - m[7];
    p[3] = m[0] - m[1] - 2 * (m[2] - m[4]) - m[3] + m[7];
    p[4] = m[0] - m[1] - 2 * (m[2] - m[6]) - m[5] - m[7];
    p[5] = m[0] + 2 * m[1] + m[2] + m[3] + m[4] + m[5] + m[6] + m[8];
    p[6] = m[0] + 2 * m[1] + m[2] - m[3] - m[4] + m[5] + m[6] - m[8];
    p[7] = m[0] + 2 * m[1] + m[2] - m[3] - m[4] - m[5] - m[6] + m[8];
    p[8] = m[0] + 2 * m[1] + m[2] + m[3] + m[4] - m[5] - m[6] - m[8];
    for (int k = 0; k < 9; k++) res.p[k] = 32'(sat32(p[k]));
    return res;
  endfunction

  function automatic logic signed [31:0] corner_word();
    case ($urandom_range(0, 4))
      0: return 32'sh7FFFFFFF;
      1: return 32'sh80000000;
      2: return '0;
      3: return 32'(ONE);
      default: return $urandom;
    endcase
  endfunction

  function automatic node_t make_node();
    node_t n;
    int mode;
    mode = $urandom_range(0, 99);
    for (int k = 0; k < 9; k++) begin
      if (mode < 60) n.f[k] = 32'(ONE / 9) + $signed(32'($urandom_range(0, 33554431))) - 16777216;
      else if (mode < 85) n.f[k] = $urandom;
      else n.f[k] = corner_word();
    end
    if (mode < 60) begin
      n.rho = 32'(ONE) + $signed(32'($urandom_range(0, 67108863))) - 33554432;
      n.ux = $signed(32'($urandom_range(0, 134217727))) - 67108864;
      n.uy = $signed(32'($urandom_range(0, 134217727))) - 67108864;
    end else if (mode < 85) begin
      n.rho = $urandom;
      n.ux = $urandom;
      n.uy = $urandom;
    end else begin
      n.rho = corner_word();
      n.ux = corner_word();
      n.uy = corner_word();
    end
    return n;
  endfunction

  function automatic node_t fill_node(logic signed [31:0] fv, logic signed [31:0] rv,
                                      logic signed [31:0] uxv, logic signed [31:0] uyv);
    node_t n;
    for (int k = 0; k < 9; k++) n.f[k] = fv;
    n.rho = rv;
    n.ux = uxv;
    n.uy = uyv;
    return n;
  endfunction

  task automatic report_mismatch(string what, int idx, logic signed [31:0] got,
                                 logic signed [31:0] want);
    errors++;
    $display("mismatch %s dir %0d: got %0d expected %0d", what, idx, got, want);
  endtask

  task automatic write_rate(int idx, longint value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= mrt_pkg::CFG_IDX_W'(idx);
    cfg_data <= mrt_pkg::RATE_W'(value);
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx < 5) rate_cfg[idx] = value & 64'h3FFFFFFF;
  endtask

  task automatic drain();
    wait (pending.size() == 0 && !in_valid && post_q.size() == 0);
    repeat (15) @(posedge clk);
  endtask

  // Input driver: one transfer per accepted node, prediction taken at that edge.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) post_q.push_back(collide(cur_node));
      if (!in_valid || in_ready) begin
        if (pending.size() > 0 && ((out_count > 600 && out_count < 800) ||
            $urandom_range(0, 99) >= IDLE_PCT)) begin
          cur_node = pending.pop_front();
          {f_rest, f_east, f_north, f_west, f_south} <=
            {cur_node.f[0], cur_node.f[1], cur_node.f[2], cur_node.f[3], cur_node.f[4]};
          {f_ne, f_nw, f_sw, f_se} <= {cur_node.f[5], cur_node.f[6], cur_node.f[7], cur_node.f[8]};
          density <= cur_node.rho;
          vel_x <= cur_node.ux;
          vel_y <= cur_node.uy;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Output monitor with a single long hold-off so that the pipeline backs up.
  always @(posedge clk) begin
    post_t want;
    logic signed [31:0] got [9];
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        got = '{post_rest, post_east, post_north, post_west, post_south,
                post_ne, post_nw, post_sw, post_se};
        if (post_q.size() == 0) begin
          report_mismatch("unexpected transfer", 0, got[0], 0);
        end else begin
          want = post_q.pop_front();
          for (int k = 0; k < 9; k++)
            if (got[k] !== want.p[k]) report_mismatch("post", k, got[k], want.p[k]);
        end
        out_count++;
      end
      if (!hold_done && out_count == 300) begin
        hold_done = 1;
        hold = 80;
      end
      if (hold > 0) begin
        hold--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= (out_count > 600 && out_count < 800) || $urandom_range(0, 99) >= IDLE_PCT;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || done || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet <= 0;
    end else if (quiet >= WATCHDOG_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    longint settings [5][5];
    settings = '{'{295279002, 281857229, 281857229, 281857229, 533668899},
                 '{0, 0, 0, 0, 0},
                 '{64'h3FFFFFFF, 64'h3FFFFFFF, 64'h3FFFFFFF, 64'h3FFFFFFF, 64'h3FFFFFFF},
                 '{268435456, 1, 536870912, 134217728, 402653184},
                 '{536870912, 300000000, 0, 64'h2AAAAAAA, 268435456}};
    rate_cfg = '{295279002, 281857229, 281857229, 281857229, 533668899};
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    pending.push_back(fill_node('0, '0, '0, '0));
    pending.push_back(fill_node(32'(ONE / 9), 32'(ONE), '0, '0));
    pending.push_back(fill_node(32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF));
    pending.push_back(fill_node(32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000));
    pending.push_back(fill_node(32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000));
    pending.push_back(fill_node(32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF));
    pending.push_back(fill_node(-1, -1, -1, -1));
    pending.push_back(fill_node(32'(ONE / 9), 32'(ONE), 32'(ONE / 10), -32'(ONE / 20)));
    for (int k = 0; k < 9; k++) begin
      node_t n;
      n = fill_node('0, 32'(ONE), '0, '0);
      n.f[k] = 32'sh7FFFFFFF;
      pending.push_back(n);
      n.f[k] = 32'sh80000000;
      pending.push_back(n);
    end
    drain();

    for (int s = 0; s < 5; s++) begin
      for (int i = 0; i < 5; i++) write_rate(i, settings[s][i]);
      // Indexes past the register list must leave every rate untouched.
      if (s == 2) for (int i = 5; i < 8; i++) write_rate(i, $urandom_range(0, 1073741823));
      for (int i = 0; i < 265; i++) pending.push_back(make_node());
      drain();
    end

    done = 1;
    if (errors == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/mrt_pkg.sv
rtl/mrt_moments.sv
rtl/mrt_equil.sv
rtl/mrt_relax.sv
rtl/mrt_back.sv
rtl/d2q9_mrt_collision.sv
rtl/mrt_check.sv
verif/tb.sv
